@@ rtl/svdp_pkg.sv @@
`timescale 1ns / 1ps

package svdp_pkg;

    localparam int DEPTH_DEF    = 256;
    localparam int DIM_BITS_DEF = 20;

    // request codes
    localparam logic [1:0] FUNC_LOAD_A = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B = 2'd1;
    localparam logic [1:0] FUNC_DOT    = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_ZERO  = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_ORDER = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [19:0]        dim_index;
        logic signed [31:0] weight;
    } svdp_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [63:0] dot_sum;
        logic               sum_valid;
    } svdp_rsp_t;

    typedef struct packed {
        logic push;
        logic clear;
    } svdp_store_ctl_t;

    typedef struct packed {
        logic clear;
        logic valid;
    } svdp_mac_ctl_t;

endpackage

@@ rtl/sparse_vector_dot_product_top.sv @@
`timescale 1ns / 1ps
// load and unused requests: result strobe in the cycle after the request, busy stays low
// compute request: the merge walk (S_WALK) advances one entry per cycle on the two
//   store read ports, then the two-stage multiply-accumulate drains (S_DRAIN) and
//   the result is strobed
// busy is high for the whole compute walk and drain; results cannot be stalled by the receiver
// reset (async, active low) empties both vectors and clears the accumulator

module sparse_vector_dot_product_top
    import svdp_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int DIM_BITS = DIM_BITS_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  svdp_req_t req,
    output logic      done,
    output svdp_rsp_t rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN
    } state_t;

    state_t              state_reg;
    logic [CW-1:0]       i_reg;
    logic [CW-1:0]       j_reg;
    logic [CW-1:0]       i_next;
    logic [CW-1:0]       j_next;
    logic                done_reg;
    svdp_rsp_t           rsp_reg;

    // store side
    svdp_store_ctl_t     ctl_a;
    svdp_store_ctl_t     ctl_b;
    logic [DIM_BITS-1:0] dim_in;
    logic [DIM_BITS-1:0] idx_a;
    logic [DIM_BITS-1:0] idx_b;
    logic signed [31:0]  wt_a;
    logic signed [31:0]  wt_b;
    logic [CW-1:0]       count_a;
    logic [CW-1:0]       count_b;
    logic [DIM_BITS-1:0] last_a;
    logic [DIM_BITS-1:0] last_b;
    logic [AW-1:0]       rd_addr_a;
    logic [AW-1:0]       rd_addr_b;

    // append check
    logic                accept;
    logic                sel_b;
    logic [CW-1:0]       sel_count;
    logic [DIM_BITS-1:0] sel_last;
    logic [1:0]          app_status;

    // merge walk
    svdp_mac_ctl_t       mac_ctl;
    logic                mac_pending;
    logic signed [63:0]  mac_acc;
    logic                walk_end;
    logic                finish;

    // only the low DIM_BITS of the index take part
    assign dim_in = DIM_BITS'(req.dim_index);

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // append checks, in priority order: zero weight, full, out of order
    always_comb
    begin
        sel_b     = (req.func == FUNC_LOAD_B);
        sel_count = sel_b ? count_b : count_a;
        sel_last  = sel_b ? last_b : last_a;
        if (req.weight == 32'sd0)
        begin
            app_status = STAT_ZERO;
        end
        else if (sel_count == CW'(DEPTH))
        begin
            app_status = STAT_FULL;
        end
        else if (sel_count != '0 && dim_in <= sel_last)
        begin
            app_status = STAT_ORDER;
        end
        else
        begin
            app_status = STAT_OK;
        end
    end

    // merge step: advance the smaller index, both on a match
    always_comb
    begin
        walk_end     = (i_reg == count_a) || (j_reg == count_b);
        i_next       = i_reg;
        j_next       = j_reg;
        mac_ctl      = '0;
        if (state_reg == S_WALK && !walk_end)
        begin
            if (idx_a < idx_b)
            begin
                i_next = i_reg + CW'(1);
            end
            else if (idx_a > idx_b)
            begin
                j_next = j_reg + CW'(1);
            end
            else
            begin
                i_next        = i_reg + CW'(1);
                j_next        = j_reg + CW'(1);
                mac_ctl.valid = 1'b1;
            end
        end
        mac_ctl.clear = accept && (req.func == FUNC_DOT);
    end

    // result ready once the product stage has emptied
    assign finish = (state_reg == S_DRAIN) && !mac_pending;

    // read address follows the next pointer so data lines up with the walk
    always_comb
    begin
        if (state_reg == S_WALK)
        begin
            rd_addr_a = i_next[AW-1:0];
            rd_addr_b = j_next[AW-1:0];
        end
        else
        begin
            rd_addr_a = '0;
            rd_addr_b = '0;
        end
    end

    always_comb
    begin
        ctl_a.push  = accept && (req.func == FUNC_LOAD_A) && (app_status == STAT_OK);
        ctl_b.push  = accept && (req.func == FUNC_LOAD_B) && (app_status == STAT_OK);
        ctl_a.clear = finish;
        ctl_b.clear = finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            done_reg  <= 1'b0;
            rsp_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (req.func) inside
                            FUNC_LOAD_A, FUNC_LOAD_B:
                            begin
                                done_reg          <= 1'b1;
                                rsp_reg.status    <= app_status;
                                rsp_reg.dot_sum   <= '0;
                                rsp_reg.sum_valid <= 1'b0;
                            end
                            FUNC_DOT:
                            begin
                                state_reg <= S_WALK;
                                i_reg     <= '0;
                                j_reg     <= '0;
                            end
                            default:
                            begin
                                // unused code: empty result, state unchanged
                                done_reg          <= 1'b1;
                                rsp_reg.status    <= STAT_OK;
                                rsp_reg.dot_sum   <= '0;
                                rsp_reg.sum_valid <= 1'b0;
                            end
                        endcase
                    end
                end
                S_WALK:
                begin
                    i_reg <= i_next;
                    j_reg <= j_next;
                    if (walk_end)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (finish)
                    begin
                        state_reg         <= S_IDLE;
                        done_reg          <= 1'b1;
                        rsp_reg.status    <= STAT_OK;
                        rsp_reg.dot_sum   <= mac_acc;
                        rsp_reg.sum_valid <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    svdp_store #(
        .DEPTH    (DEPTH),
        .DIM_BITS (DIM_BITS)
    ) u_store_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_a),
        .wr_idx    (dim_in),
        .wr_weight (req.weight),
        .rd_addr   (rd_addr_a),
        .rd_idx    (idx_a),
        .rd_weight (wt_a),
        .count     (count_a),
        .last_idx  (last_a)
    );

    svdp_store #(
        .DEPTH    (DEPTH),
        .DIM_BITS (DIM_BITS)
    ) u_store_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_b),
        .wr_idx    (dim_in),
        .wr_weight (req.weight),
        .rd_addr   (rd_addr_b),
        .rd_idx    (idx_b),
        .rd_weight (wt_b),
        .count     (count_b),
        .last_idx  (last_b)
    );

    svdp_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .a       (wt_a),
        .b       (wt_b),
        .pending (mac_pending),
        .acc     (mac_acc)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_busy_from_dot: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && req.func == FUNC_DOT))
        else $error("busy without compute request");

    a_plain_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.sum_valid) |-> rsp.dot_sum == 64'sd0)
        else $error("nonzero sum on load result");

    a_mac_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        mac_ctl.valid |-> state_reg == S_WALK)
        else $error("product issued outside walk");

endmodule

@@ rtl/svdp_store.sv @@
`timescale 1ns / 1ps

module svdp_store
    import svdp_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int DIM_BITS = DIM_BITS_DEF,
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW      = $clog2(DEPTH + 1)
)(
    input  logic                clk,
    input  logic                rst_n,
    input  svdp_store_ctl_t     ctl,
    input  logic [DIM_BITS-1:0] wr_idx,
    input  logic signed [31:0]  wr_weight,
    input  logic [AW-1:0]       rd_addr,
    output logic [DIM_BITS-1:0] rd_idx,
    output logic signed [31:0]  rd_weight,
    output logic [CW-1:0]       count,
    output logic [DIM_BITS-1:0] last_idx
);

    logic [DIM_BITS-1:0]       idx_mem [DEPTH];
    logic signed [31:0]        wt_mem  [DEPTH];
    logic [CW-1:0]             count_reg;
    logic [DIM_BITS-1:0]       last_reg;
    logic [DIM_BITS-1:0]       rd_idx_reg;
    logic signed [31:0]        rd_wt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.clear)
        begin
            count_reg <= '0;
        end
        else if (ctl.push)
        begin
            count_reg <= count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            idx_mem[count_reg[AW-1:0]] <= wr_idx;
            wt_mem[count_reg[AW-1:0]]  <= wr_weight;
            last_reg                   <= wr_idx;
        end
        rd_idx_reg <= idx_mem[rd_addr];
        rd_wt_reg  <= wt_mem[rd_addr];
    end

    assign rd_idx    = rd_idx_reg;
    assign rd_weight = rd_wt_reg;
    assign count     = count_reg;
    assign last_idx  = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("store count above depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> count_reg != CW'(DEPTH))
        else $error("push into full store");

endmodule

@@ rtl/svdp_mac.sv @@
`timescale 1ns / 1ps

module svdp_mac
    import svdp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  svdp_mac_ctl_t      ctl,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic               pending,
    output logic signed [63:0] acc
);

    logic               prod_valid_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [64:0] sum_wide;
    logic signed [63:0] acc_next;

    // saturating add: overflow when the two top bits of the wide sum differ
    always_comb
    begin
        sum_wide = {acc_reg[63], acc_reg} + {prod_reg[63], prod_reg};
        if (sum_wide[64] != sum_wide[63])
        begin
            acc_next = sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        else
        begin
            acc_next = sum_wide[63:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            prod_valid_reg <= ctl.valid && !ctl.clear;
            if (ctl.clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_valid_reg)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign pending = prod_valid_reg;
    assign acc     = acc_reg;

endmodule

@@ dv/tb_sparse_vector_dot_product_top.sv @@
`timescale 1ns / 1ps

module tb_sparse_vector_dot_product_top;
    import svdp_pkg::*;

    // scoreboard: mirrors both sparse vectors and keeps the expected responses in order
    class svdp_scoreboard;
        logic [19:0]        dim_store [2][DEPTH_DEF];
        logic signed [31:0] wt_store  [2][DEPTH_DEF];
        int unsigned        count [2];
        svdp_rsp_t          expected_q [$];
        int unsigned        errors;
        int unsigned        status_hits [4];
        int unsigned        dots;
        int unsigned        dots_empty;
        int unsigned        dots_saturated;

        function new();
            count[0] = 0;
            count[1] = 0;
            errors = 0;
            dots = 0;
            dots_empty = 0;
            dots_saturated = 0;
            foreach (status_hits[k])
                status_hits[k] = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // zero weight wins over full, full wins over order
        function logic [1:0] append_entry(int vec, logic [19:0] dim, logic signed [31:0] w);
            if (w == 0)
                return STAT_ZERO;
            if (count[vec] >= DEPTH_DEF)
                return STAT_FULL;
            if (count[vec] > 0 && dim <= dim_store[vec][count[vec] - 1])
                return STAT_ORDER;
            dim_store[vec][count[vec]] = dim;
            wt_store[vec][count[vec]] = w;
            count[vec]++;
            return STAT_OK;
        endfunction

        // merge walk over both sorted lists, saturating q32.32 accumulate
        function logic signed [63:0] merge_sum();
            logic signed [64:0] acc;
            logic signed [63:0] prod;
            int unsigned        i;
            int unsigned        j;
            bit                 clipped;
            acc = '0;
            i = 0;
            j = 0;
            clipped = 0;
            while (i < count[0] && j < count[1])
            begin
                if (dim_store[0][i] < dim_store[1][j])
                    i++;
                else if (dim_store[0][i] > dim_store[1][j])
                    j++;
                else
                begin
                    prod = longint'(wt_store[0][i]) * longint'(wt_store[1][j]);
                    acc = acc + prod;
                    if (acc[64:63] == 2'b01)
                    begin
                        acc = {2'b00, {63{1'b1}}};
                        clipped = 1;
                    end
                    else if (acc[64:63] == 2'b10)
                    begin
                        acc = {2'b11, 63'd0};
                        clipped = 1;
                    end
                    i++;
                    j++;
                end
            end
            if (clipped)
                dots_saturated++;
            return acc[63:0];
        endfunction

        function void note_request(svdp_req_t r);
            svdp_rsp_t exp_rsp;
            exp_rsp = '0;
            case (r.func)
                FUNC_LOAD_A:
                    exp_rsp.status = append_entry(0, r.dim_index, r.weight);
                FUNC_LOAD_B:
                    exp_rsp.status = append_entry(1, r.dim_index, r.weight);
                FUNC_DOT:
                begin
                    dots++;
                    if (count[0] != 0 && count[1] != 0)
                        exp_rsp.dot_sum = merge_sum();
                    else
                        dots_empty++;
                    exp_rsp.sum_valid = 1'b1;
                    count[0] = 0;
                    count[1] = 0;
                end
                default: ;
            endcase
            if (r.func == FUNC_LOAD_A || r.func == FUNC_LOAD_B)
                status_hits[exp_rsp.status]++;
            expected_q.push_back(exp_rsp);
        endfunction

        function void check_result(svdp_rsp_t act);
            svdp_rsp_t exp_rsp;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected response status=%0d dot_sum=%0d sum_valid=%0b",
                         $time, act.status, act.dot_sum, act.sum_valid);
                return;
            end
            exp_rsp = expected_q.pop_front();
            if (act.status !== exp_rsp.status)
            begin
                errors++;
                $display("%0t: status mismatch expected %0d actual %0d",
                         $time, exp_rsp.status, act.status);
            end
            if (act.dot_sum !== exp_rsp.dot_sum)
            begin
                errors++;
                $display("%0t: dot_sum mismatch expected %0d actual %0d",
                         $time, exp_rsp.dot_sum, act.dot_sum);
            end
            if (act.sum_valid !== exp_rsp.sum_valid)
            begin
                errors++;
                $display("%0t: sum_valid mismatch expected %0b actual %0b",
                         $time, exp_rsp.sum_valid, act.sum_valid);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    svdp_req_t req;
    logic      done;
    svdp_rsp_t rsp;

    svdp_scoreboard sb;
    int unsigned    idle_pct;
    int unsigned    requests_sent;

    sparse_vector_dot_product_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog, far beyond the slowest legal run of the stimulus below
    initial
    begin
        #2_000_000;
        $display("%0t: timeout, %0d responses still outstanding", $time, sb.pending());
        $display("status: fail");
        $finish;
    end

    // response monitor: a strobed response is only valid for one cycle, sample every edge
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(rsp);
    end

    // drive one request; called at a falling edge and returns at a falling edge
    // random idle cycles go before the request, the request is taken at the first
    // rising edge that sees busy low
    task automatic send_req(svdp_req_t r);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(r);
        if (r.func != FUNC_NONE)
            requests_sent++;
        @(negedge clk);
    endtask

    task automatic send_fields(logic [1:0] f, logic [19:0] dim, logic signed [31:0] w);
        svdp_req_t r;
        r.func = f;
        r.dim_index = dim;
        r.weight = w;
        send_req(r);
    endtask

    // hold off the sender until every outstanding response has arrived
    task automatic wait_drain();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // weights lean toward the extremes and values near one so products matter
    function automatic logic signed [31:0] pick_weight();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 5)
            return '0;
        if (k < 13)
            return 32'sh8000_0000;
        if (k < 21)
            return 32'sh7fff_ffff;
        if (k < 50)
            return $signed(32'($urandom_range(0, 196608))) - 32'sd98304;
        return $urandom;
    endfunction

    // a stray request slipped into a load sequence
    task automatic send_noise(logic [1:0] vec_func);
        case ($urandom_range(3))
            0: send_fields(vec_func, 20'($urandom), '0);
            // index zero is out of order once anything is stored
            1: send_fields(vec_func, '0, pick_weight());
            2: send_fields(FUNC_NONE, 20'($urandom), $urandom);
            default: send_fields(2'($urandom), 20'($urandom), $urandom);
        endcase
    endtask

    // one well-formed pair of vectors with shared indices, loads interleaved, then a
    // dot product; overfill pushes extra loads into whichever vector is full
    task automatic run_vector_pair(int unsigned n_a, int unsigned n_b, bit overfill);
        svdp_req_t   qa [$];
        svdp_req_t   qb [$];
        svdp_req_t   r;
        int unsigned total;
        int unsigned step_max;
        int unsigned pos;
        int unsigned pick;
        logic [1:0]  full_func;
        total = n_a + n_b;
        step_max = 1 << $urandom_range(0, 12);
        if ((total + 1) * step_max > 20'hFFFFF)
            step_max = 1;
        pos = $urandom_range(0, 20'hFFFFF - (total + 1) * step_max);
        while (qa.size() < n_a || qb.size() < n_b)
        begin
            pos += $urandom_range(1, step_max);
            pick = $urandom_range(9);
            r.dim_index = 20'(pos);
            if (pick < 4 && qa.size() < n_a && qb.size() < n_b)
            begin
                r.func = FUNC_LOAD_A;
                r.weight = pick_weight();
                qa.push_back(r);
                r.func = FUNC_LOAD_B;
                r.weight = pick_weight();
                qb.push_back(r);
            end
            else if ((pick < 7 && qa.size() < n_a) || qb.size() >= n_b)
            begin
                r.func = FUNC_LOAD_A;
                r.weight = pick_weight();
                qa.push_back(r);
            end
            else
            begin
                r.func = FUNC_LOAD_B;
                r.weight = pick_weight();
                qb.push_back(r);
            end
        end
        while (qa.size() != 0 || qb.size() != 0)
        begin
            if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(1)))
                r = qa.pop_front();
            else
                r = qb.pop_front();
            if ($urandom_range(99) < 5)
                send_noise(r.func);
            send_req(r);
        end
        if (overfill)
        begin
            // full vector: a fitting index is refused, zero weight still reports first,
            // a stale index reports full before out of order
            full_func = (n_a >= DEPTH_DEF) ? FUNC_LOAD_A : FUNC_LOAD_B;
            send_fields(full_func, 20'hFFFFF, pick_weight() | 32'sd1);
            send_fields(full_func, 20'hFFFFF, '0);
            send_fields(full_func, '0, 32'sh0001_0000);
        end
        send_fields(FUNC_DOT, 20'($urandom), $urandom);
    endtask

    task automatic run_directed();
        // dot product of two empty vectors
        send_fields(FUNC_DOT, 20'hFFFFF, 32'shFFFF_FFFF);
        // unused code leaves the vectors alone
        send_fields(FUNC_NONE, 20'h5A5A5, 32'sh1234_5678);
        // mixed loads: equal index, lower index, zero weight, top index
        send_fields(FUNC_LOAD_A, 20'd5, 32'sh0001_0000);
        send_fields(FUNC_LOAD_A, 20'd5, 32'sd2);
        send_fields(FUNC_LOAD_A, 20'd3, 32'sd1);
        send_fields(FUNC_LOAD_A, 20'd10, '0);
        send_fields(FUNC_LOAD_A, 20'hFFFFF, 32'sh7fff_ffff);
        send_fields(FUNC_LOAD_B, 20'd5, -32'sh0001_0000);
        send_fields(FUNC_LOAD_B, 20'd7, 32'sd3);
        send_fields(FUNC_LOAD_B, 20'hFFFFF, 32'sh8000_0000);
        send_fields(FUNC_DOT, '0, '0);
        // only one side loaded
        send_fields(FUNC_LOAD_A, 20'd0, 32'sd1);
        send_fields(FUNC_DOT, '0, '0);
        // two min by min products clip at the positive limit
        send_fields(FUNC_LOAD_A, 20'd0, 32'sh8000_0000);
        send_fields(FUNC_LOAD_A, 20'd1, 32'sh8000_0000);
        send_fields(FUNC_LOAD_B, 20'd0, 32'sh8000_0000);
        send_fields(FUNC_LOAD_B, 20'd1, 32'sh8000_0000);
        send_fields(FUNC_DOT, '0, '0);
        // three min by max products clip at the negative limit
        send_fields(FUNC_LOAD_A, 20'd2, 32'sh8000_0000);
        send_fields(FUNC_LOAD_A, 20'd3, 32'sh8000_0000);
        send_fields(FUNC_LOAD_A, 20'd4, 32'sh8000_0000);
        send_fields(FUNC_LOAD_B, 20'd2, 32'sh7fff_ffff);
        send_fields(FUNC_LOAD_B, 20'd3, 32'sh7fff_ffff);
        send_fields(FUNC_LOAD_B, 20'd4, 32'sh7fff_ffff);
        send_fields(FUNC_DOT, '0, '0);
    endtask

    // pick a sequence shape: mostly small pairs, some empty sides, a few medium
    // and now and then a vector filled to the brim
    task automatic run_random_pair();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 2)
        begin
            if ($urandom_range(1))
                run_vector_pair(DEPTH_DEF, $urandom_range(1, 24), 1'b1);
            else
                run_vector_pair($urandom_range(1, 24), DEPTH_DEF, 1'b1);
        end
        else if (k < 8)
        begin
            if ($urandom_range(1))
                run_vector_pair(0, $urandom_range(0, 6), 1'b0);
            else
                run_vector_pair($urandom_range(0, 6), 0, 1'b0);
        end
        else if (k < 90)
            run_vector_pair($urandom_range(1, 12), $urandom_range(1, 12), 1'b0);
        else
            run_vector_pair($urandom_range(13, 64), $urandom_range(13, 64), 1'b0);
    endtask

    initial
    begin
        int unsigned phase_idle [3];
        int unsigned phase_end;
        phase_idle[0] = 26;
        phase_idle[1] = 73;
        phase_idle[2] = 0;
        sb = new();
        idle_pct = 0;
        requests_sent = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        wait_drain();

        // three phases of random traffic, sender idling at 26, 73 and then 0 percent;
        // the sender stops and lets the block drain between phases
        for (int p = 0; p < 3; p++)
        begin
            idle_pct = phase_idle[p];
            phase_end = 25 + (p + 1) * 410;
            if (p == 0)
                run_vector_pair(DEPTH_DEF, $urandom_range(4, 30), 1'b1);
            while (requests_sent < phase_end)
                run_random_pair();
            wait_drain();
        end

        // let a late compute response still arrive before the final report
        repeat (2 * DEPTH_DEF + 16) @(posedge clk);

        $display("covered %0d requests, %0d dot products (%0d clipped, %0d with an empty side)",
                 requests_sent, sb.dots, sb.dots_saturated, sb.dots_empty);
        $display("append outcomes: ok %0d, zero dropped %0d, full %0d, out of order %0d",
                 sb.status_hits[STAT_OK], sb.status_hits[STAT_ZERO],
                 sb.status_hits[STAT_FULL], sb.status_hits[STAT_ORDER]);
        if (sb.pending() != 0)
            $display("%0t: %0d expected responses never arrived", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/svdp_pkg.sv
rtl/svdp_store.sv
rtl/svdp_mac.sv
rtl/sparse_vector_dot_product_top.sv
dv/tb_sparse_vector_dot_product_top.sv
